[rtl/lk2_pkg.sv]
// Shared types, constants and the mix step function of the lookup2 hash block.
// Used by the mix pipeline and the top level; depends on nothing.
`default_nettype none

package lk2_pkg;

    localparam logic [31:0] GOLDEN_WORD = 32'h9e3779b9;
    localparam logic [31:0] DEFAULT_C   = 32'hfedcba98;

    // One 12-byte block: bytes 0..3 feed a, 4..7 feed b, 8..11 feed c.
    localparam int          BLOCK_BYTES = 12;
    localparam logic [3:0]  POS_B_START = 4'd4;
    localparam logic [3:0]  POS_C_START = 4'd8;
    localparam logic [3:0]  POS_LAST    = 4'(BLOCK_BYTES - 1);

    // The mix is nine dependent subtract/xor lines, one pipeline stage each.
    localparam int MIX_STEPS = 9;
    localparam int STEP_W    = $clog2(MIX_STEPS);

    typedef struct packed {
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] c;
    } word3_t;

    typedef struct packed {
        logic        first;
        logic        same;
        logic [31:0] tail_a;
        logic [31:0] tail_b;
        logic [31:0] tail_c;
        logic [31:0] key_c;
    } final_job_t;

    // One line of the mix: one word loses the other two and takes a shifted copy.
    function automatic word3_t mix_line(input logic [STEP_W-1:0] step, input word3_t w);
        word3_t r;
        r = w;
        case (step)
            4'd0:    r.a = (w.a - w.b - w.c) ^ (w.c >> 13);
            4'd1:    r.b = (w.b - w.c - w.a) ^ (w.a << 8);
            4'd2:    r.c = (w.c - w.a - w.b) ^ (w.b >> 13);
            4'd3:    r.a = (w.a - w.b - w.c) ^ (w.c >> 12);
            4'd4:    r.b = (w.b - w.c - w.a) ^ (w.a << 16);
            4'd5:    r.c = (w.c - w.a - w.b) ^ (w.b >> 5);
            4'd6:    r.a = (w.a - w.b - w.c) ^ (w.c >> 3);
            4'd7:    r.b = (w.b - w.c - w.a) ^ (w.a << 10);
            4'd8:    r.c = (w.c - w.a - w.b) ^ (w.b >> 15);
            default: r = w;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

[rtl/lk2_mix_pipe.sv]
// Nine-stage pipeline of the lookup2 mix, one mix line per stage.
// Depends on lk2_pkg for the word type and the mix line function.
`default_nettype none

module lk2_mix_pipe (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            en,
    input  logic            in_valid,
    input  lk2_pkg::word3_t in_word,
    output logic            out_valid,
    output lk2_pkg::word3_t out_word
);

    lk2_pkg::word3_t stage_reg  [lk2_pkg::MIX_STEPS];
    lk2_pkg::word3_t stage_next [lk2_pkg::MIX_STEPS];
    logic            valid_reg  [lk2_pkg::MIX_STEPS];
    logic            valid_next [lk2_pkg::MIX_STEPS];

    for (genvar g = 0; g < lk2_pkg::MIX_STEPS; g++) begin : g_stage
        if (g == 0) begin : g_head
            assign stage_next[g] = lk2_pkg::mix_line(lk2_pkg::STEP_W'(g), in_word);
            assign valid_next[g] = in_valid;
        end
        else begin : g_body
            assign stage_next[g] = lk2_pkg::mix_line(lk2_pkg::STEP_W'(g), stage_reg[g-1]);
            assign valid_next[g] = valid_reg[g-1];
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[g] <= 1'b0;
            end
            else if (en)
            begin
                valid_reg[g] <= valid_next[g];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                stage_reg[g] <= stage_next[g];
            end
        end
    end

    assign out_valid = valid_reg[lk2_pkg::MIX_STEPS-1];
    assign out_word  = stage_reg[lk2_pkg::MIX_STEPS-1];

endmodule

`default_nettype wire

[rtl/jenkins_lookup2_hash32.sv]
// Top level of the streaming 32-bit lookup2 hash: byte packing, block and
// final scheduling, two mix pipelines and the result register. Uses lk2_pkg, lk2_mix_pipe.
//
//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+-------------------------------------
//  key     | in        | key_valid / key_stall   | key_byte, byte_present, last_item
//  hash    | out       | hash_valid / hash_stall | hash_value
//  cfg     | in        | cfg_valid / cfg_ready   | cfg_data (initial_c)
//
// One key byte is taken every cycle while key_stall is low. A hash for the request
// that ends its key passes a 9-stage block mix pipeline, then a 9-stage final mix pipeline.
// Blocks of one key lie a full 12 key bytes apart, so a block mix finishes before
// the next block of the same key needs its result.
// key_stall rises only while a result waits stalled in the output register and the
// next result has reached the end of the final pipeline; the whole pipeline then holds.
// Reset is asynchronous; initial_c returns to 0xfedcba98. cfg_ready is always high.
`default_nettype none

module jenkins_lookup2_hash32 (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        key_valid,
    output logic        key_stall,
    input  logic [7:0]  key_byte,
    input  logic        byte_present,
    input  logic        last_item,
    output logic        hash_valid,
    input  logic        hash_stall,
    output logic [31:0] hash_value,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [31:0] cfg_data
);

    localparam int FIN_LAST = lk2_pkg::MIX_STEPS;

    logic en;
    logic item_acc;
    logic cfg_wr;

    // Configuration and per-key starting value of c.
    logic [31:0] initial_c_reg, initial_c_next;
    logic [31:0] key_c_reg, key_c_next;

    // Front end: the block being assembled.
    logic [31:0] a_word_reg, a_word_next;
    logic [31:0] b_word_reg, b_word_next;
    logic [23:0] held_reg, held_next;
    logic [3:0]  pos_reg, pos_next;
    logic [31:0] len_reg, len_next;
    logic        key_open_reg, key_open_next;
    logic        had_block_reg, had_block_next;

    logic                blk_now;
    logic                fin_now;
    lk2_pkg::word3_t     blk_word;
    lk2_pkg::final_job_t fin_job;

    // Block mix request, entering the block pipeline.
    logic            blk_valid_reg;
    logic            blk_first_reg;
    lk2_pkg::word3_t blk_word_reg;
    logic [31:0]     blk_key_c_reg;
    lk2_pkg::word3_t p1_in;
    logic            p1_valid;
    lk2_pkg::word3_t p1_word;
    lk2_pkg::word3_t committed_reg;

    // Final requests travel beside the block pipeline to meet its result.
    lk2_pkg::final_job_t fin_reg       [FIN_LAST+1];
    logic                fin_valid_reg [FIN_LAST+1];
    lk2_pkg::final_job_t fin_out;
    lk2_pkg::word3_t     fin_base;
    lk2_pkg::word3_t     p2_in;
    logic                p2_valid;
    lk2_pkg::word3_t     p2_word;

    logic        hash_valid_reg;
    logic [31:0] hash_value_reg;

    assign en        = !(p2_valid && hash_valid_reg && hash_stall);
    assign key_stall = !en;
    assign item_acc  = key_valid && en;
    assign cfg_ready = 1'b1;
    assign cfg_wr    = cfg_valid;

    always_comb
    begin
        initial_c_next = cfg_wr ? cfg_data : initial_c_reg;
        if (cfg_wr && !key_open_reg)
        begin
            key_c_next = cfg_data;
        end
        else if (item_acc && last_item)
        begin
            key_c_next = initial_c_reg;
        end
        else
        begin
            key_c_next = key_c_reg;
        end
    end

    always_comb
    begin
        a_word_next    = a_word_reg;
        b_word_next    = b_word_reg;
        held_next      = held_reg;
        pos_next       = pos_reg;
        len_next       = len_reg;
        key_open_next  = key_open_reg;
        had_block_next = had_block_reg;
        blk_now        = 1'b0;
        fin_now        = 1'b0;
        blk_word       = '{a: a_word_reg, b: b_word_reg, c: {key_byte, held_reg}};
        fin_job        = '0;

        if (item_acc && byte_present)
        begin
            len_next      = len_reg + 32'd1;
            key_open_next = 1'b1;
            if (pos_reg < lk2_pkg::POS_B_START)
            begin
                a_word_next[{pos_reg[1:0], 3'b000} +: 8] = key_byte;
            end
            else if (pos_reg < lk2_pkg::POS_C_START)
            begin
                b_word_next[{pos_reg[1:0], 3'b000} +: 8] = key_byte;
            end
            else if (pos_reg < lk2_pkg::POS_LAST)
            begin
                held_next[{pos_reg[1:0], 3'b000} +: 8] = key_byte;
            end

            if (pos_reg >= lk2_pkg::POS_LAST)
            begin
                blk_now        = 1'b1;
                had_block_next = 1'b1;
                pos_next       = '0;
                a_word_next    = '0;
                b_word_next    = '0;
                held_next      = '0;
            end
            else
            begin
                pos_next = pos_reg + 4'd1;
            end
        end

        if (item_acc && last_item)
        begin
            fin_now       = 1'b1;
            fin_job.first = !(had_block_reg || blk_now);
            fin_job.same  = blk_now;
            fin_job.key_c = key_c_reg;
            if (blk_now)
            begin
                fin_job.tail_c = len_next;
            end
            else
            begin
                // A short tail puts its c bytes one byte higher than a full block.
                fin_job.tail_a = a_word_next;
                fin_job.tail_b = b_word_next;
                fin_job.tail_c = len_next + {held_next, 8'h00};
            end
            a_word_next    = '0;
            b_word_next    = '0;
            held_next      = '0;
            pos_next       = '0;
            len_next       = '0;
            key_open_next  = 1'b0;
            had_block_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            initial_c_reg <= lk2_pkg::DEFAULT_C;
            key_c_reg     <= lk2_pkg::DEFAULT_C;
            a_word_reg    <= '0;
            b_word_reg    <= '0;
            held_reg      <= '0;
            pos_reg       <= '0;
            len_reg       <= '0;
            key_open_reg  <= 1'b0;
            had_block_reg <= 1'b0;
        end
        else
        begin
            initial_c_reg <= initial_c_next;
            key_c_reg     <= key_c_next;
            a_word_reg    <= a_word_next;
            b_word_reg    <= b_word_next;
            held_reg      <= held_next;
            pos_reg       <= pos_next;
            len_reg       <= len_next;
            key_open_reg  <= key_open_next;
            had_block_reg <= had_block_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            blk_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            blk_valid_reg <= blk_now;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en && blk_now)
        begin
            blk_first_reg <= !had_block_reg;
            blk_word_reg  <= blk_word;
            blk_key_c_reg <= key_c_reg;
        end
    end

    // The first block of a key starts from the fresh words, later ones from the last mix.
    always_comb
    begin
        if (blk_first_reg)
        begin
            p1_in.a = lk2_pkg::GOLDEN_WORD + blk_word_reg.a;
            p1_in.b = lk2_pkg::GOLDEN_WORD + blk_word_reg.b;
            p1_in.c = blk_key_c_reg + blk_word_reg.c;
        end
        else
        begin
            p1_in.a = committed_reg.a + blk_word_reg.a;
            p1_in.b = committed_reg.b + blk_word_reg.b;
            p1_in.c = committed_reg.c + blk_word_reg.c;
        end
    end

    lk2_mix_pipe u_block_mix (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (blk_valid_reg),
        .in_word   (p1_in),
        .out_valid (p1_valid),
        .out_word  (p1_word)
    );

    always_ff @(posedge clk)
    begin
        if (en && p1_valid)
        begin
            committed_reg <= p1_word;
        end
    end

    for (genvar g = 0; g <= FIN_LAST; g++) begin : g_fin
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                fin_valid_reg[g] <= 1'b0;
            end
            else if (en)
            begin
                fin_valid_reg[g] <= (g == 0) ? fin_now : fin_valid_reg[(g == 0) ? 0 : g-1];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                fin_reg[g] <= (g == 0) ? fin_job : fin_reg[(g == 0) ? 0 : g-1];
            end
        end
    end

    assign fin_out = fin_reg[FIN_LAST];

    // A block ending on the same request leaves the block pipeline in this very cycle.
    always_comb
    begin
        if (fin_out.first)
        begin
            fin_base = '{a: lk2_pkg::GOLDEN_WORD, b: lk2_pkg::GOLDEN_WORD, c: fin_out.key_c};
        end
        else if (fin_out.same)
        begin
            fin_base = p1_word;
        end
        else
        begin
            fin_base = committed_reg;
        end
        p2_in.a = fin_base.a + fin_out.tail_a;
        p2_in.b = fin_base.b + fin_out.tail_b;
        p2_in.c = fin_base.c + fin_out.tail_c;
    end

    lk2_mix_pipe u_final_mix (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (fin_valid_reg[FIN_LAST]),
        .in_word   (p2_in),
        .out_valid (p2_valid),
        .out_word  (p2_word)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hash_valid_reg <= 1'b0;
        end
        else if (p2_valid && en)
        begin
            hash_valid_reg <= 1'b1;
        end
        else if (!hash_stall)
        begin
            hash_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (p2_valid && en)
        begin
            hash_value_reg <= p2_word.c;
        end
    end

    assign hash_valid = hash_valid_reg;
    assign hash_value = hash_value_reg;

endmodule

`default_nettype wire

[rtl/lk2_checker.sv]
// Port-level checks of the lookup2 hash block and the bind that attaches them.
// Sees only the top level's ports; depends on jenkins_lookup2_hash32.
`default_nettype none

module lk2_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        key_stall,
    input logic        hash_valid,
    input logic        hash_stall,
    input logic [31:0] hash_value
);

    // A stalled result stays offered.
    a_hash_hold: assert property (@(posedge clk) disable iff (!rst_n)
        hash_valid && hash_stall |=> hash_valid)
        else $error("hash_valid dropped while stalled");

    // A stalled result keeps its value.
    a_hash_stable: assert property (@(posedge clk) disable iff (!rst_n)
        hash_valid && hash_stall |=> $stable(hash_value))
        else $error("hash_value changed while stalled");

    // The key side is held back only by a result stuck on the hash side.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        key_stall |-> hash_valid && hash_stall)
        else $error("key_stall without a stalled result");

    // In reset no result is offered and requests are not refused.
    a_reset_quiet: assert property (@(posedge clk)
        !rst_n |-> !hash_valid && !key_stall)
        else $error("outputs active during reset");

endmodule

bind jenkins_lookup2_hash32 lk2_checker u_lk2_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .key_stall  (key_stall),
    .hash_valid (hash_valid),
    .hash_stall (hash_stall),
    .hash_value (hash_value)
);

`default_nettype wire
